@@ src/ttcp_pkg.sv @@
// Package: constants, codes and types for the track table conflict predictor.
`timescale 1ns / 1ps
package ttcp_pkg;
	localparam int MaxTracks  = 8;
	localparam int MaxResults = 29;
	localparam int IdxW = $clog2(MaxTracks);
	localparam int CntW = $clog2(MaxTracks + 1);

	localparam logic [1:0] CMD_UPSERT  = 2'd0;
	localparam logic [1:0] CMD_REMOVE  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP  = 2'd2;
	localparam logic [1:0] CMD_PREDICT = 2'd3;

	localparam logic [1:0] KIND_ACK      = 2'd0;
	localparam logic [1:0] KIND_CONFLICT = 2'd1;
	localparam logic [1:0] KIND_END      = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_HORIZON  = 2'd3;

	localparam logic [1:0] REG_HORIZON = 2'd0;
	localparam logic [1:0] REG_HLIMIT  = 2'd1;
	localparam logic [1:0] REG_VLIMIT  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_SHIFT, S_PRED, S_CMP, S_EMIT, S_END, S_ACK
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [9:0]  report_step;
		logic [15:0] first_id;
		logic [15:0] second_id;
		logic [31:0] first_x;
		logic [31:0] first_y;
		logic [31:0] first_z;
		logic [31:0] second_x;
		logic [31:0] second_y;
		logic [31:0] second_z;
		logic        last;
	} result_t;
endpackage

@@ src/track_table_conflict_predictor_top.sv @@
// Top level of the track table conflict predictor.
`timescale 1ns / 1ps
// Usage: commands enter on the s_axis channel (one item per command, the
// opcode on tuser), results leave on m_axis (the result kind on tuser),
// registers are written on the cfg channel while idle; the user must keep
// to that, the block does not enforce it. Upsert, remove and lookup search
// the table one entry a cycle, a remove then shifts later entries one a
// cycle; one ack follows. Predict at a step at or past the horizon only
// acks with the horizon status; else it computes one axis of one track per
// cycle (one shared multiply-add), then compares one axis of one pair per
// cycle while no conflict waits to be sent (up to 28 pairs), sending each
// conflict and a final scan end with tlast.
// s_axis_tready is low while a command is in work or a result is held.
// A stalled receiver holds the output register and pauses the scan.
// Reset clears the track count, the registers to 180, 3000, 1000 and drops
// any held result; table contents are not cleared.
module track_table_conflict_predictor_top import ttcp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// track_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, step_index
	input  logic [175:0] s_axis_tdata,
	// command
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, report_step, first_id, second_id, first_x/y/z, second_x/y/z
	output logic [239:0] m_axis_tdata,
	// kind
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);
	result_t res;
	ttcp_top_core u_core (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser), .in_id(s_axis_tdata[15:0]),
		.in_pos(s_axis_tdata[111:16]), .in_vel(s_axis_tdata[159:112]),
		.in_step(s_axis_tdata[169:160]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);
	assign m_axis_tdata = {4'd0, res.second_z, res.second_y, res.second_x, res.first_z,
		res.first_y, res.first_x, res.second_id, res.first_id, res.report_step,
		res.status};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;
endmodule

@@ src/ttcp_cmp_unit.sv @@
// Shared separation compare: exact signed difference magnitude against a limit.
`timescale 1ns / 1ps
module ttcp_cmp_unit import ttcp_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [15:0] limit,
	output logic        fits
);
	logic signed [32:0] diff;
	logic [32:0] mag;
	// Take the exact difference, then its magnitude
	always_comb begin
		diff = 33'(signed'(a)) - 33'(signed'(b));
		mag = diff[32] ? 33'(-diff) : 33'(diff);
		fits = mag <= {17'd0, limit};
	end
endmodule

@@ src/ttcp_top_core.sv @@
// Sequencer, track table and output register of the conflict predictor.
`timescale 1ns / 1ps
module ttcp_top_core import ttcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_cmd,
	input  logic [15:0] in_id,
	input  logic [95:0] in_pos,
	input  logic [47:0] in_vel,
	input  logic [9:0]  in_step,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_res
);
	state_t state_q, state_d;
	logic [9:0]  horizon_q;
	logic [15:0] hlim_q, vlim_q;
	logic [15:0] ids_q [MaxTracks];
	logic [95:0] pos_q [MaxTracks];
	logic [47:0] vel_q [MaxTracks];
	logic [95:0] pred_q [MaxTracks];
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] i_q, j_q;
	logic [1:0]  cmd_q;
	logic [15:0] id_q;
	logic [95:0] ipos_q;
	logic [47:0] ivel_q;
	logic [9:0]  step_q;
	logic [1:0]  status_q;
	logic [1:0]  ax_q;
	logic        pass_q;
	logic [4:0]  nrep_q;
	logic        out_valid_q;
	result_t     res_q;
	logic        cmp_ok;
	logic [31:0] ca, cb;
	logic [15:0] clim;
	logic [IdxW-1:0] ii, jj;

	assign ii = i_q[IdxW-1:0];
	assign jj = j_q[IdxW-1:0];
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// Select one axis of the current pair for the shared compare
	always_comb begin
		ca = pred_q[ii][ax_q*32 +: 32];
		cb = pred_q[jj][ax_q*32 +: 32];
		clim = (ax_q == 2'd2) ? vlim_q : hlim_q;
	end

	ttcp_cmp_unit u_cmp (.a(ca), .b(cb), .limit(clim), .fits(cmp_ok));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid && in_ready) state_d = S_SEARCH;
			S_SEARCH: begin
				if (cmd_q == CMD_PREDICT)
					state_d = (step_q >= horizon_q) ? S_ACK : S_PRED;
				else if (i_q >= count_q || ids_q[ii] == id_q)
					state_d = (cmd_q == CMD_REMOVE && i_q < count_q) ? S_SHIFT : S_ACK;
			end
			S_SHIFT:  if (i_q + 1'b1 >= count_q) state_d = S_ACK;
			S_PRED:   if (i_q >= count_q) state_d = S_CMP;
			S_CMP: begin
				if (j_q >= count_q || nrep_q >= 5'(MaxResults - 1)) state_d = S_END;
				else if (ax_q == 2'd2) state_d = (pass_q && cmp_ok) ? S_EMIT : S_CMP;
			end
			S_EMIT:   if (!out_valid_q) state_d = S_CMP;
			S_END:    if (!out_valid_q) state_d = S_IDLE;
			S_ACK:    if (!out_valid_q) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			horizon_q <= 10'd180;
			hlim_q <= 16'd3000;
			vlim_q <= 16'd1000;
			count_q <= '0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			ax_q <= '0;
			pass_q <= 1'b0;
			nrep_q <= '0;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			// Configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_HORIZON: horizon_q <= cfg_data[9:0];
					REG_HLIMIT:  hlim_q <= cfg_data;
					REG_VLIMIT:  vlim_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					nrep_q <= '0;
					if (in_valid && in_ready) begin
						cmd_q <= in_cmd; id_q <= in_id; ipos_q <= in_pos;
						ivel_q <= in_vel; step_q <= in_step;
					end
				end
				S_SEARCH: begin
					if (cmd_q == CMD_PREDICT) begin
						status_q <= (step_q >= horizon_q) ? ST_HORIZON : ST_OK;
					end else if (i_q < count_q && ids_q[ii] == id_q) begin
						status_q <= ST_OK;
						if (cmd_q == CMD_UPSERT) begin
							pos_q[ii] <= ipos_q; vel_q[ii] <= ivel_q;
						end
					end else if (i_q >= count_q) begin
						if (cmd_q == CMD_UPSERT) begin
							if (count_q >= CntW'(MaxTracks)) status_q <= ST_FULL;
							else begin
								status_q <= ST_OK;
								ids_q[ii] <= id_q; pos_q[ii] <= ipos_q;
								vel_q[ii] <= ivel_q; count_q <= count_q + 1'b1;
							end
						end else status_q <= ST_NOTFOUND;
					end else i_q <= i_q + 1'b1;
				end
				S_SHIFT: begin
					// Move the next entry down one place
					if (i_q + 1'b1 < count_q) begin
						ids_q[ii] <= ids_q[IdxW'(i_q + 1'b1)];
						pos_q[ii] <= pos_q[IdxW'(i_q + 1'b1)];
						vel_q[ii] <= vel_q[IdxW'(i_q + 1'b1)];
						i_q <= i_q + 1'b1;
					end else count_q <= count_q - 1'b1;
				end
				S_PRED: begin
					// One axis per cycle: pos + (t+1)*vel
					if (i_q < count_q) begin
						pred_q[ii][ax_q*32 +: 32] <= pos_q[ii][ax_q*32 +: 32]
							+ 32'(signed'({1'b0, step_q} + 11'd1)
							* signed'(vel_q[ii][ax_q*16 +: 16]));
						if (ax_q == 2'd2) begin
							ax_q <= '0; i_q <= i_q + 1'b1;
						end else ax_q <= ax_q + 1'b1;
					end else begin
						i_q <= '0; j_q <= CntW'(1); ax_q <= '0; pass_q <= 1'b1;
					end
				end
				S_CMP: begin
					if (j_q < count_q && nrep_q < 5'(MaxResults - 1)) begin
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							pass_q <= 1'b1;
							if (!(pass_q && cmp_ok)) begin
								if (j_q + 1'b1 >= count_q) begin
									i_q <= i_q + 1'b1; j_q <= i_q + 2'd2;
								end else j_q <= j_q + 1'b1;
							end
						end else begin
							ax_q <= ax_q + 1'b1;
							pass_q <= pass_q && cmp_ok;
						end
					end
				end
				S_EMIT: if (!out_valid_q) begin
					out_valid_q <= 1'b1;
					res_q <= '{KIND_CONFLICT, ST_OK, step_q, ids_q[ii], ids_q[jj],
						pred_q[ii][31:0], pred_q[ii][63:32], pred_q[ii][95:64],
						pred_q[jj][31:0], pred_q[jj][63:32], pred_q[jj][95:64], 1'b0};
					nrep_q <= nrep_q + 1'b1;
					if (j_q + 1'b1 >= count_q) begin
						i_q <= i_q + 1'b1; j_q <= i_q + 2'd2;
					end else j_q <= j_q + 1'b1;
				end
				S_END: if (!out_valid_q) begin
					out_valid_q <= 1'b1;
					res_q <= '{KIND_END, ST_OK, step_q, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
						32'd0, 32'd0, 32'd0, 1'b1};
				end
				S_ACK: if (!out_valid_q) begin
					out_valid_q <= 1'b1;
					res_q <= '{KIND_ACK, status_q, 10'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
						32'd0, 32'd0, 32'd0, 1'b1};
				end
				default: ;
			endcase
		end
	end
endmodule

@@ src/ttcp_checker.sv @@
// Port checker for the track table conflict predictor, bound to the top level.
`timescale 1ns / 1ps
module ttcp_checker import ttcp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [239:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tlast
);
	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");
	// No new item while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready with result pending");
	// Conflicts never carry tlast, acks and ends always do
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_CONFLICT)))
		else $error("tlast mismatch");
	// An accepted item has no result valid in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind track_table_conflict_predictor_top ttcp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
